// ----- rtl/gcbb_pkg.sv -----
`timescale 1ns / 1ps

package gcbb_pkg;

  // fixed field widths
  localparam int unsigned CoordW   = 17;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned SdataW   = 88;
  localparam int unsigned SuserW   = 2;
  localparam int unsigned MdataW   = 64;

  // default queue depth between front and back
  localparam int unsigned FifoDepthDef = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgFore   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBack   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOpaque = 2'd2;

  // register reset values
  localparam logic [ColorW-1:0] ForeReset = 24'h000000;
  localparam logic [ColorW-1:0] BackReset = 24'hFFFFFF;

  // bitmap formats
  typedef enum logic [1:0] {
    MODE_MONO = 2'd0,
    MODE_GRAY = 2'd1,
    MODE_LCD  = 2'd2
  } mode_e;

  // one classified item waiting for the back end
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [MaskW-1:0]  emit;
    logic [MaskW-1:0]  hit;
    logic [ColorW-1:0] color_hit;
    logic [ColorW-1:0] color_miss;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

// ----- rtl/gcbb_front.sv -----
`timescale 1ns / 1ps

module gcbb_front import gcbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // origin_x, origin_y, glyph_rows, upward_flow, row_index, column_index,
  // valid_bits, cover_r, cover_g, cover_b, zero pad
  input  logic [SdataW-1:0] s_axis_tdata,
  // mode
  input  logic [SuserW-1:0] s_axis_tuser,
  input  logic [ColorW-1:0] fore_i,
  input  logic [ColorW-1:0] back_i,
  input  logic              opaque_i,
  input  fifo_st_t          fifo_st_i,
  output push_t             push_o
);

  localparam logic [7:0]        MonoFirstBit = 8'h80;
  localparam logic [7:0]        FullCover    = 8'd255;
  localparam logic [CoordW-1:0] FlowShift    = 17'd11;

  // c*fg + (255-c)*bg, fits 16 bits
  function automatic logic [15:0] mix_sum(input logic [7:0] cov, input logic [7:0] fg,
                                          input logic [7:0] bg);
    logic [15:0] a;
    logic [15:0] b;
    a = {8'd0, cov} * {8'd0, fg};
    b = {8'd0, FullCover - cov} * {8'd0, bg};
    return a + b;
  endfunction

  // floor(v / 255) for v below 65280
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // field unpack
  logic [15:0] ox, oy;
  logic [7:0]  rows, row, col, cr, cg, cb;
  logic        up;
  logic [3:0]  nbits;
  mode_e       mode;

  assign ox    = s_axis_tdata[15:0];
  assign oy    = s_axis_tdata[31:16];
  assign rows  = s_axis_tdata[39:32];
  assign up    = s_axis_tdata[40];
  assign row   = s_axis_tdata[48:41];
  assign col   = s_axis_tdata[56:49];
  assign nbits = s_axis_tdata[60:57];
  assign cr    = s_axis_tdata[68:61];
  assign cg    = s_axis_tdata[76:69];
  assign cb    = s_axis_tdata[84:77];
  assign mode  = mode_e'(s_axis_tuser);

  // coordinates
  logic [CoordW-1:0] x0, y0;
  assign x0 = {ox[15], ox} + {9'd0, col};
  assign y0 = {oy[15], oy} + {9'd0, row} + (up ? (FlowShift - {9'd0, rows}) : '0);

  // per channel blend sums
  logic [7:0]  cov_g, cov_b;
  logic [15:0] sum_r0, sum_g0, sum_b0;
  assign cov_g  = (mode == MODE_LCD) ? cg : cr;
  assign cov_b  = (mode == MODE_LCD) ? cb : cr;
  assign sum_r0 = mix_sum(cr,    fore_i[7:0],   back_i[7:0]);
  assign sum_g0 = mix_sum(cov_g, fore_i[15:8],  back_i[15:8]);
  assign sum_b0 = mix_sum(cov_b, fore_i[23:16], back_i[23:16]);

  // classify the item into pixel masks
  logic [MaskW-1:0] emit0, hit0;
  logic [3:0]       nsat;
  logic             nz;
  logic             bitv;
  always_comb begin
    emit0 = '0;
    hit0  = '0;
    nsat  = (nbits > 4'd8) ? 4'd8 : nbits;
    nz    = 1'b0;
    bitv  = 1'b0;
    case (mode)
      MODE_MONO: begin
        for (int k = 0; k < MaskW; k++) begin
          bitv     = |(cr & (MonoFirstBit >> k));
          hit0[k]  = (4'(k) < nsat) & bitv;
          emit0[k] = (4'(k) < nsat) & (bitv | opaque_i);
        end
      end
      MODE_GRAY: begin
        nz    = (cr != 8'd0);
        emit0 = {7'd0, nz | opaque_i};
        hit0  = {7'd0, nz};
      end
      MODE_LCD: begin
        nz    = ((cr | cg | cb) != 8'd0);
        emit0 = {7'd0, nz | opaque_i};
        hit0  = {7'd0, nz};
      end
      default: begin
        emit0 = '0;
        hit0  = '0;
      end
    endcase
  end

  // stage register
  logic              s1_valid_q;
  logic [CoordW-1:0] s1_x_q, s1_y_q;
  logic [MaskW-1:0]  s1_emit_q, s1_hit_q;
  logic              s1_mono_q;
  logic [15:0]       s1_sr_q, s1_sg_q, s1_sb_q;
  logic              advance;

  assign advance       = s1_valid_q & ((s1_emit_q == '0) | ~fifo_st_i.full);
  assign s_axis_tready = ~s1_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_x_q    <= x0;
      s1_y_q    <= y0;
      s1_emit_q <= emit0;
      s1_hit_q  <= hit0;
      s1_mono_q <= (mode == MODE_MONO);
      s1_sr_q   <= sum_r0;
      s1_sg_q   <= sum_g0;
      s1_sb_q   <= sum_b0;
    end
  end

  // queue write, items without pixels are dropped here
  always_comb begin
    push_o.push             = s1_valid_q & (s1_emit_q != '0) & ~fifo_st_i.full;
    push_o.entry.x          = s1_x_q;
    push_o.entry.y          = s1_y_q;
    push_o.entry.emit       = s1_emit_q;
    push_o.entry.hit        = s1_hit_q;
    push_o.entry.color_hit  = s1_mono_q ? fore_i
                            : {div255(s1_sb_q), div255(s1_sg_q), div255(s1_sr_q)};
    push_o.entry.color_miss = back_i;
  end

endmodule

// ----- rtl/gcbb_fifo.sv -----
`timescale 1ns / 1ps

module gcbb_fifo import gcbb_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  push_t    push_i,
  input  logic     pop_i,
  output entry_t   head_o,
  output fifo_st_t st_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign st_o.full  = (cnt_q == CntFull);
  assign st_o.empty = (cnt_q == '0);
  assign head_o     = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i.push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i.push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/gcbb_back.sv -----
`timescale 1ns / 1ps

module gcbb_back import gcbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  entry_t            head_i,
  input  fifo_st_t          fifo_st_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [MdataW-1:0] m_axis_tdata,
  // last_of_item
  output logic              m_axis_tlast
);

  logic [MaskW-1:0] done_q;
  logic [MaskW-1:0] rem, onehot;
  logic [2:0]       idx;
  logic             last, load;
  logic             out_valid_q;

  // next pixel of the head item: lowest pending bit
  assign rem    = head_i.emit & ~done_q;
  assign onehot = rem & (~rem + 8'd1);
  assign last   = ((rem & ~onehot) == '0);

  always_comb begin
    idx = '0;
    for (int k = MaskW - 1; k >= 0; k--) begin
      if (rem[k]) begin
        idx = 3'(k);
      end
    end
  end

  assign load  = ~fifo_st_i.empty & (~out_valid_q | m_axis_tready);
  assign pop_o = load & last;

  // progress through the head item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        done_q <= last ? '0 : (done_q | onehot);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  logic [CoordW-1:0] px_q, py_q;
  logic [ColorW-1:0] color_q;
  logic              last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q    <= head_i.x + {14'd0, idx};
      py_q    <= head_i.y;
      color_q <= ((head_i.hit & onehot) != '0) ? head_i.color_hit : head_i.color_miss;
      last_q  <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, color_q, py_q, px_q};
  assign m_axis_tlast  = last_q;

endmodule

// ----- rtl/glyph_coverage_blend_blit_core.sv -----
`timescale 1ns / 1ps
// path: the first pixel write passes the front register, the queue and the output
//   register, in that order
// throughput: gray and lcd items 1 per cycle while the output accepts; a mono byte
//   writes 1 pixel per cycle, up to 8, set by the single pixel port of the back end
// the front end keeps accepting while the queue (FifoDepth items) has room
// reset: asynchronous active low; colors and opaque fill return to reset values,
//   queue and output empty

module glyph_coverage_blend_blit_core import gcbb_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // glyph elements
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // origin_x, origin_y, glyph_rows, upward_flow, row_index, column_index,
  // valid_bits, cover_r, cover_g, cover_b, zero pad
  input  logic [SdataW-1:0]   s_axis_tdata,
  // mode
  input  logic [SuserW-1:0]   s_axis_tuser,
  // pixel writes
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [MdataW-1:0]   m_axis_tdata,
  // last_of_item
  output logic                m_axis_tlast
);

  // configuration registers
  logic [ColorW-1:0] fore_q, back_q;
  logic              opaque_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q   <= ForeReset;
      back_q   <= BackReset;
      opaque_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFore:   fore_q   <= cfg_data_i[ColorW-1:0];
        CfgBack:   back_q   <= cfg_data_i[ColorW-1:0];
        CfgOpaque: opaque_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  push_t    push;
  entry_t   head;
  fifo_st_t fifo_st;
  logic     pop;

  gcbb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fore_i        (fore_q),
    .back_i        (back_q),
    .opaque_i      (opaque_q),
    .fifo_st_i     (fifo_st),
    .push_o        (push)
  );

  gcbb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .st_o   (fifo_st)
  );

  gcbb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_st_i     (fifo_st),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // queue never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push.push |-> !fifo_st.full)
    else $error("push into full queue");

  // queue never drained when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !fifo_st.empty)
    else $error("pop from empty queue");

  // retiring an item always presents its final pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("item retired without last pixel");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import gcbb_pkg::*;

  localparam int unsigned FullCover  = 255;
  localparam int          FlowShift  = 11;
  localparam logic [7:0]  MonoFirstBit = 8'h80;
  localparam logic [1:0]  ModeUnused = 2'd3;
  localparam int          MonoMaxBits = 8;
  localparam int          DrainCycles = 20;
  localparam int          CycleLimit  = 300000;
  localparam int          HoldCycles  = 120;
  localparam int          HoldAfter   = 50;
  localparam int          MaxReports  = 40;

  // one glyph bitmap element as offered on the input stream
  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [7:0]         rows;
    logic               up;
    logic [7:0]         row;
    logic [7:0]         col;
    logic [3:0]         vbits;
    logic [7:0]         cr;
    logic [7:0]         cg;
    logic [7:0]         cb;
  } glyph_elem_t;

  // one pixel write on the output stream
  typedef struct {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_wr_t;

  logic clk;
  logic rst_ni = 1'b0;

  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SdataW-1:0]  s_axis_tdata;
  logic [SuserW-1:0]  s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MdataW-1:0]  m_axis_tdata;
  logic               m_axis_tlast;

  glyph_elem_t bus_elem = '{default: '0};

  // register copies used for prediction
  logic [ColorW-1:0] fore_rgb  = ForeReset;
  logic [ColorW-1:0] back_rgb  = BackReset;
  logic              opaque_on = 1'b0;

  glyph_elem_t pending_elems[$];
  pixel_wr_t   expected_pixels[$];

  int issue_cnt  = 0;
  int accept_cnt = 0;
  int errors     = 0;
  int cycles     = 0;

  // input fields packed from the lowest bit up
  assign s_axis_tdata = {3'b000, bus_elem.cb, bus_elem.cg, bus_elem.cr, bus_elem.vbits,
                         bus_elem.col, bus_elem.row, bus_elem.up, bus_elem.rows,
                         bus_elem.oy, bus_elem.ox};
  assign s_axis_tuser = bus_elem.mode;

  glyph_coverage_blend_blit_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // per-channel coverage blend, truncating divide by full cover
  function automatic logic [ColorW-1:0] blend_color(logic [7:0] cr, logic [7:0] cg,
                                                    logic [7:0] cb);
    logic [7:0]        cov [3];
    logic [ColorW-1:0] res;
    int unsigned       c;
    int unsigned       fg;
    int unsigned       bg;
    cov[0] = cr;
    cov[1] = cg;
    cov[2] = cb;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      c  = cov[i];
      fg = fore_rgb[8*i +: 8];
      bg = back_rgb[8*i +: 8];
      res[8*i +: 8] = 8'((c * fg + (FullCover - c) * bg) / FullCover);
    end
    return res;
  endfunction

  // expected pixel writes for one accepted element
  function automatic void predict_pixels(glyph_elem_t e);
    pixel_wr_t wr[$];
    pixel_wr_t p;
    int        x;
    int        y;
    int        nb;
    logic      hit;
    x = int'(e.ox) + int'(e.col);
    y = int'(e.oy) + int'(e.row) + (e.up ? FlowShift - int'(e.rows) : 0);
    p.y    = y[CoordW-1:0];
    p.last = 1'b0;
    case (e.mode)
      MODE_MONO: begin
        nb = (e.vbits > MonoMaxBits) ? MonoMaxBits : int'(e.vbits);
        for (int k = 0; k < nb; k++) begin
          hit = (e.cr & (MonoFirstBit >> k)) != 0;
          if (hit || opaque_on) begin
            p.x     = CoordW'(x + k);
            p.color = hit ? fore_rgb : back_rgb;
            wr.push_back(p);
          end
        end
      end
      MODE_GRAY, MODE_LCD: begin
        p.x = x[CoordW-1:0];
        if (e.mode == MODE_GRAY && e.cr != 0) begin
          p.color = blend_color(e.cr, e.cr, e.cr);
          wr.push_back(p);
        end else if (e.mode == MODE_LCD && (e.cr | e.cg | e.cb) != 0) begin
          p.color = blend_color(e.cr, e.cg, e.cb);
          wr.push_back(p);
        end else if (opaque_on) begin
          p.color = back_rgb;
          wr.push_back(p);
        end
      end
      default: ;
    endcase
    if (wr.size() > 0) wr[wr.size()-1].last = 1'b1;
    foreach (wr[i]) expected_pixels.push_back(wr[i]);
  endfunction

  function automatic glyph_elem_t elem(int mode, int ox, int oy, int rows, int up, int row,
                                       int col, int vbits, int cr, int cg, int cb);
    glyph_elem_t e;
    e.mode  = 2'(mode);
    e.ox    = 16'(ox);
    e.oy    = 16'(oy);
    e.rows  = 8'(rows);
    e.up    = 1'(up);
    e.row   = 8'(row);
    e.col   = 8'(col);
    e.vbits = 4'(vbits);
    e.cr    = 8'(cr);
    e.cg    = 8'(cg);
    e.cb    = 8'(cb);
    return e;
  endfunction

  // mostly well-formed elements, some zero coverage, bad widths and unused mode
  function automatic glyph_elem_t rand_elem();
    glyph_elem_t e;
    int          r;
    e = elem($urandom_range(0, 2), $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom_range(1, 8), $urandom, $urandom, $urandom);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      e.cr = '0;
    end else if (r < 14) begin
      e.cr = '0;
      e.cg = '0;
      e.cb = '0;
    end else if (r < 18) begin
      e.cr = 8'hFF;
    end else if (r < 22) begin
      e.vbits = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
    end else if (r < 25) begin
      e.mode = ModeUnused;
    end
    return e;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // element driver
  int send_gap  = 0;
  int send_calm = 0;
  always @(negedge clk) begin
    if (rst_ni && (!s_axis_tvalid || accept_cnt == issue_cnt)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_elems.size() > 0) begin
        bus_elem      <= pending_elems.pop_front();
        s_axis_tvalid <= 1'b1;
        issue_cnt++;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 29) == 0) send_calm = 25;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // pixel receiver, with one long hold-off to back up the block
  int   recv_gap  = 0;
  int   recv_calm = 0;
  int   hold_left = 0;
  logic held_off  = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held_off && accept_cnt >= HoldAfter) begin
      held_off  = 1'b1;
      hold_left = HoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm--;
      end else begin
        recv_gap = pick_gap();
        if ($urandom_range(0, 29) == 0) recv_calm = 25;
      end
    end
  end

  task automatic report_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    if (errors <= MaxReports)
      $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
  endtask

  // check pixel writes, then predict from the element accepted at this edge
  always @(posedge clk) begin
    pixel_wr_t got;
    pixel_wr_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x     = m_axis_tdata[CoordW-1:0];
        got.y     = m_axis_tdata[2*CoordW-1:CoordW];
        got.color = m_axis_tdata[2*CoordW+ColorW-1:2*CoordW];
        got.last  = m_axis_tlast;
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel write with none pending, x", '0, got.x);
        end else begin
          want = expected_pixels.pop_front();
          if (got.x != want.x) report_mismatch("pixel_x", want.x, got.x);
          if (got.y != want.y) report_mismatch("pixel_y", want.y, got.y);
          if (got.color != want.color) report_mismatch("pixel_color", want.color, got.color);
          if (got.last != want.last) report_mismatch("last_of_item", want.last, got.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixels(bus_elem);
        accept_cnt++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgFore:   fore_rgb  = val[ColorW-1:0];
      CfgBack:   back_rgb  = val[ColorW-1:0];
      CfgOpaque: opaque_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_colors(logic [ColorW-1:0] fore, logic [ColorW-1:0] back, logic opq);
    write_reg(CfgFore, fore);
    write_reg(CfgBack, back);
    write_reg(CfgOpaque, CfgDataW'(opq));
  endtask

  // all elements taken and all pixels seen, then let the pipeline drain
  task automatic wait_idle();
    do @(negedge clk);
    while (!(pending_elems.size() == 0 && accept_cnt == issue_cnt &&
             expected_pixels.size() == 0));
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) pending_elems.push_back(rand_elem());
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset colors, transparent: coordinate extremes, skipped writes
    pending_elems.push_back(elem(MODE_MONO, 32767, 32767, 0, 0, 255, 255, 8, 8'hFF, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, -32768, -32768, 255, 1, 0, 0, 8, 8'hA5, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, 0, 0, 0, 0, 0, 0, 8, 8'h00, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, 5, 5, 10, 1, 3, 16, 0, 8'hFF, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, 100, -100, 12, 1, 4, 8, 15, 8'h81, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, -7, 9, 20, 0, 2, 40, 3, 8'hE0, 0, 0));
    pending_elems.push_back(elem(MODE_GRAY, 1, 2, 5, 0, 1, 1, 0, 8'h00, 0, 0));
    pending_elems.push_back(elem(MODE_GRAY, 1, 2, 5, 0, 1, 2, 0, 8'hFF, 0, 0));
    pending_elems.push_back(elem(MODE_GRAY, 1, 2, 5, 1, 1, 3, 0, 8'h01, 0, 0));
    pending_elems.push_back(elem(MODE_GRAY, 1, 2, 5, 0, 1, 4, 0, 8'h80, 0, 0));
    pending_elems.push_back(elem(MODE_LCD, -300, 300, 9, 0, 7, 7, 0, 0, 0, 0));
    pending_elems.push_back(elem(MODE_LCD, -300, 300, 9, 1, 7, 8, 0, 255, 0, 128));
    pending_elems.push_back(elem(MODE_LCD, -300, 300, 9, 0, 7, 9, 0, 1, 254, 255));
    pending_elems.push_back(elem(ModeUnused, 0, 0, 0, 0, 0, 0, 8, 8'hFF, 8'hFF, 8'hFF));
    wait_idle();

    // inverted colors, opaque: background fills for clear bits and zero coverage
    set_colors(24'hFFFFFF, 24'h000000, 1'b1);
    pending_elems.push_back(elem(MODE_MONO, 10, 20, 4, 0, 1, 0, 8, 8'h5A, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, 10, 20, 4, 0, 1, 8, 8, 8'h00, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, 10, 20, 4, 0, 1, 16, 0, 8'h00, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, 10, 20, 4, 1, 1, 24, 12, 8'h3C, 0, 0));
    pending_elems.push_back(elem(MODE_MONO, -1, -1, 0, 1, 0, 0, 1, 8'h80, 0, 0));
    pending_elems.push_back(elem(MODE_GRAY, 0, 0, 3, 0, 2, 2, 0, 8'h00, 0, 0));
    pending_elems.push_back(elem(MODE_GRAY, 0, 0, 3, 0, 2, 3, 0, 8'hFF, 0, 0));
    pending_elems.push_back(elem(MODE_GRAY, 0, 0, 3, 0, 2, 4, 0, 8'd77, 0, 0));
    pending_elems.push_back(elem(MODE_LCD, 0, 0, 3, 0, 2, 5, 0, 0, 0, 0));
    pending_elems.push_back(elem(MODE_LCD, 0, 0, 3, 0, 2, 6, 0, 200, 0, 0));
    pending_elems.push_back(elem(ModeUnused, 0, 0, 3, 0, 2, 7, 8, 0, 0, 0));
    wait_idle();

    // random phases over several register settings
    set_colors(ColorW'($urandom), ColorW'($urandom), 1'b0);
    run_random(15);
    set_colors(ColorW'($urandom), ColorW'($urandom), 1'b1);
    run_random(15);
    set_colors(24'h000000, 24'h000000, 1'b1);
    run_random(15);
    set_colors(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    run_random(15);
    set_colors(ColorW'($urandom), ColorW'($urandom), 1'b1);
    run_random(15);

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
